/* rtl/lpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_pkg - shared types and table generator for the log-domain probability ALU
// Operation and compare codes, plus the elaboration-time builder for the
// ln(1 + exp(-d)) correction table.
// ----------------------------------------------------------------------------
package lpa_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_CMP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_e;

  localparam int unsigned CFG_WIDTH  = 5;
  localparam int unsigned INT_FRAC   = 30;  // internal table precision
  localparam int unsigned RANGE_LOG2 = 5;   // table covers d in [0, 32)
  localparam logic [63:0] LN2_Q30    = 64'd744261118;

  // Shift-subtract quotient, elaboration use only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-x), x and result in Q30
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] x);
    logic [63:0] k;
    logic [63:0] r;
    logic [63:0] term;
    longint      acc;
    logic [63:0] res;
    k    = udiv64(x, LN2_Q30);
    r    = x - k * LN2_Q30;
    acc  = longint'(64'd1 << INT_FRAC);
    term = 64'd1 << INT_FRAC;
    for (int n = 1; n <= 24; n++) begin
      if (term != 0) begin
        term = udiv64((term * r) >> INT_FRAC, 64'(n));
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
    end
    if (k >= 64'd62 || acc <= 0) res = '0;
    else res = 64'(acc) >> k;
    return res;
  endfunction

  // ln(1 + u), Q30, via 2 * atanh(u / (2 + u))
  function automatic logic [63:0] log1p_q30(input logic [63:0] u);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] s;
    logic [63:0] p;
    z  = udiv64(u << INT_FRAC, (64'd1 << (INT_FRAC + 1)) + u);
    z2 = (z * z) >> INT_FRAC;
    s  = z;
    p  = z;
    for (int n = 3; n < 200; n += 2) begin
      if (p != 0) begin
        p = (p * z2) >> INT_FRAC;
        s = s + udiv64(p, 64'(n));
      end
    end
    return 2 * s;
  endfunction

  // One correction entry at the segment midpoint, rounded to frac_bits.
  function automatic logic [63:0] corr_entry(input int idx, input int frac_bits,
                                             input int tab_bits);
    logic [63:0] x;
    logic [63:0] f;
    logic [63:0] half;
    int          sh;
    x = (64'(2 * idx) + 64'd1) << (RANGE_LOG2 + INT_FRAC - 1 - tab_bits);
    f = log1p_q30(exp_neg_q30(x));
    if (frac_bits <= INT_FRAC) begin
      sh   = INT_FRAC - frac_bits;
      half = (sh > 0) ? (64'd1 << (sh - 1)) : 64'd0;
      f    = (f + half) >> sh;
    end else begin
      f = f << (frac_bits - INT_FRAC);
    end
    return f;
  endfunction

endpackage

/* rtl/lpa_corr_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_corr_rom - correction table ROM
// ln(1 + exp(-d)) per segment, contents fixed at elaboration, registered read
// with a hold enable for pipeline stalls.
// ----------------------------------------------------------------------------
module lpa_corr_rom #(
  parameter int FRACTION_BITS      = 24,
  parameter int TABLE_ADDRESS_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [TABLE_ADDRESS_BITS-1:0] addr_i,
  output logic [FRACTION_BITS-1:0]      data_o
);

  localparam int Depth = 2 ** TABLE_ADDRESS_BITS;

  logic [FRACTION_BITS-1:0] rom_w [Depth];
  logic [FRACTION_BITS-1:0] data_q;

  for (genvar i = 0; i < Depth; i++) begin : g_entry
    localparam logic [63:0] Entry = lpa_pkg::corr_entry(i, FRACTION_BITS, TABLE_ADDRESS_BITS);
    assign rom_w[i] = Entry[FRACTION_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

/* rtl/log_domain_probability_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_domain_probability_alu - add, multiply, divide and compare on
// probabilities held as fixed-point natural logs
// ----------------------------------------------------------------------------
// Each word carries two log-probabilities (signed, FRACTION_BITS fraction
// bits) with zero-probability flags and an operation code in tuser. Add gives
// max(a,b) + ln(1 + exp(-|a-b|)), the correction taken from a constant ROM
// of 2^TABLE_ADDRESS_BITS segments over |a-b| < 32; multiply and divide add
// or subtract the logs; compare gives equal/less/greater, the equality test
// masking the low equality_ignore_bits bits. Overflow saturates and sets
// range_error, as does a divide by zero probability. Throughput is one word
// per clock while the output is not back-pressured; each word passes the
// three pipeline stages (difference/sum, ROM read with mul/div/compare
// resolution, correction add and select) up to the output register. Each
// stage holds under back-pressure and bubbles close up, so the input is
// ready whenever any stage ahead has room. The config register must only be
// written while the pipeline is empty; its write channel is always ready.
// ----------------------------------------------------------------------------
module log_domain_probability_alu #(
  parameter int VALUE_WIDTH        = 40,
  parameter int FRACTION_BITS      = 24,
  parameter int TABLE_ADDRESS_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write channel: equality_ignore_bits
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [lpa_pkg::CFG_WIDTH-1:0] cfg_data_i,
  // input words
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // tdata, from bit 0: a_value, a_is_zero, b_value, b_is_zero, zero padding
  input  logic [((2*VALUE_WIDTH+2+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: operation
  input  logic [1:0]               s_axis_tuser_i,
  // result words
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // tdata, from bit 0: result_value, result_is_zero, range_error,
  // compare_code, zero padding
  output logic [((VALUE_WIDTH+4+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int VW        = VALUE_WIDTH;
  localparam int FB        = FRACTION_BITS;
  localparam int TAB       = TABLE_ADDRESS_BITS;
  localparam int OutW      = ((VW + 4 + 7) / 8) * 8;
  // sign-extended xor width for the equality mask (ignore count up to 31)
  localparam int XW        = ((VW > 32) ? VW : 32) + 1;
  // |a-b| extended far enough to test against 2^(FB+5)
  localparam int RangeBits = FB + lpa_pkg::RANGE_LOG2;
  localparam int ExtW      = ((VW > RangeBits) ? VW : RangeBits) + 1;
  localparam int IdxShift  = RangeBits - TAB;
  localparam int IdxShR    = (IdxShift >= 0) ? IdxShift : 0;
  localparam int IdxShL    = (IdxShift >= 0) ? 0 : -IdxShift;
  localparam int AddW      = ((VW > FB) ? VW : FB) + 2;

  localparam logic [VW-1:0] MaxVal = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] MinVal = {1'b1, {(VW-1){1'b0}}};

  // ---------------- configuration register ----------------
  logic [lpa_pkg::CFG_WIDTH-1:0] cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // ---------------- pipeline control ----------------
  // A stage moves on when it is empty or the stage after it moves.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3 = !v3_q || m_axis_tready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign s_axis_tready_o = adv1;
  assign m_axis_tvalid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // ---------------- stage 1: unpack, sum and difference ----------------
  logic [VW-1:0]   a_in, b_in;
  logic [VW:0]     sum1_d, diff1_d;

  logic            [VW-1:0] a1_q, b1_q;
  logic            [VW:0]   sum1_q, diff1_q;
  logic                     az1_q, bz1_q;
  lpa_pkg::op_e             op1_q;

  assign a_in    = s_axis_tdata_i[VW-1:0];
  assign b_in    = s_axis_tdata_i[2*VW:VW+1];
  assign sum1_d  = {a_in[VW-1], a_in} + {b_in[VW-1], b_in};
  assign diff1_d = {a_in[VW-1], a_in} - {b_in[VW-1], b_in};

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      a1_q    <= a_in;
      b1_q    <= b_in;
      az1_q   <= s_axis_tdata_i[VW];
      bz1_q   <= s_axis_tdata_i[2*VW+1];
      op1_q   <= lpa_pkg::op_e'(s_axis_tuser_i);
      sum1_q  <= sum1_d;
      diff1_q <= diff1_d;
    end
  end

  // ---------------- stage 2: ROM address, mul/div/compare ----------------
  logic [VW:0]     absd;
  logic [ExtW-1:0] absd_ext;
  logic            in_range2_d;
  logic [TAB-1:0]  rom_addr;
  logic [VW-1:0]   hi2_d;
  logic [XW-1:0]   xr_ext;
  logic [XW-1:0]   keep;
  logic            eq_hit;
  logic            sum_ovf, diff_ovf;
  logic [VW-1:0]   sum_sat, diff_sat;

  // resolved result for everything except an add of two non-zero operands
  logic [VW-1:0]   rv2_d;
  logic            rz2_d, err2_d, add2_d;
  lpa_pkg::cmp_e   cmp2_d;

  logic [VW-1:0]   rv2_q, hi2_q;
  logic            rz2_q, err2_q, add2_q, in_range2_q;
  lpa_pkg::cmp_e   cmp2_q;
  logic [FB-1:0]   corr_rd;

  always_comb begin
    absd     = diff1_q[VW] ? (~diff1_q + 1'b1) : diff1_q;
    absd_ext = ExtW'(absd[VW-1:0]);
    // |a-b| of 32 or more gets no correction
    in_range2_d = (absd_ext >> RangeBits) == '0;
    if (IdxShift >= 0) rom_addr = TAB'(absd_ext >> IdxShR);
    else rom_addr = TAB'(absd_ext << IdxShL);
    hi2_d = diff1_q[VW] ? b1_q : a1_q;
  end

  always_comb begin
    sum_ovf  = sum1_q[VW] != sum1_q[VW-1];
    diff_ovf = diff1_q[VW] != diff1_q[VW-1];
    sum_sat  = sum_ovf ? (sum1_q[VW] ? MinVal : MaxVal) : sum1_q[VW-1:0];
    diff_sat = diff_ovf ? (diff1_q[VW] ? MinVal : MaxVal) : diff1_q[VW-1:0];
    xr_ext   = XW'($signed(a1_q ^ b1_q));
    keep     = ~((XW'(1) << cfg_q) - XW'(1));
    eq_hit   = (xr_ext & keep) == '0;
  end

  always_comb begin
    rv2_d  = '0;
    rz2_d  = 1'b0;
    err2_d = 1'b0;
    add2_d = 1'b0;
    cmp2_d = lpa_pkg::CMP_EQ;
    case (op1_q)
      lpa_pkg::OP_ADD: begin
        if (az1_q) begin
          rz2_d = bz1_q;
          rv2_d = bz1_q ? '0 : b1_q;
        end else if (bz1_q) begin
          rv2_d = a1_q;
        end else begin
          add2_d = 1'b1;
        end
      end
      lpa_pkg::OP_MUL: begin
        if (az1_q || bz1_q) begin
          rz2_d = 1'b1;
        end else begin
          rv2_d  = sum_sat;
          err2_d = sum_ovf;
        end
      end
      lpa_pkg::OP_DIV: begin
        if (bz1_q) begin
          rv2_d  = MaxVal;
          err2_d = 1'b1;
        end else if (az1_q) begin
          rz2_d = 1'b1;
        end else begin
          rv2_d  = diff_sat;
          err2_d = diff_ovf;
        end
      end
      lpa_pkg::OP_CMP: begin
        if (az1_q && bz1_q) cmp2_d = lpa_pkg::CMP_EQ;
        else if (az1_q) cmp2_d = lpa_pkg::CMP_LT;
        else if (bz1_q) cmp2_d = lpa_pkg::CMP_GT;
        else if (eq_hit) cmp2_d = lpa_pkg::CMP_EQ;
        else if (diff1_q[VW]) cmp2_d = lpa_pkg::CMP_LT;
        else cmp2_d = lpa_pkg::CMP_GT;
      end
      default: begin
        rv2_d = '0;
      end
    endcase
  end

  lpa_corr_rom #(
    .FRACTION_BITS      (FB),
    .TABLE_ADDRESS_BITS (TAB)
  ) u_corr_rom (
    .clk_i  (clk_i),
    .en_i   (adv2),
    .addr_i (rom_addr),
    .data_o (corr_rd)
  );

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      rv2_q       <= rv2_d;
      rz2_q       <= rz2_d;
      err2_q      <= err2_d;
      add2_q      <= add2_d;
      cmp2_q      <= cmp2_d;
      hi2_q       <= hi2_d;
      in_range2_q <= in_range2_d;
    end
  end

  // ---------------- stage 3: correction add, select, output register ------
  logic [AddW-1:0] corr_ext;
  logic [AddW-1:0] lse_sum;
  logic            lse_ovf;
  logic [VW-1:0]   rv3_d;
  logic            err3_d;

  logic [VW-1:0]   rv3_q;
  logic            rz3_q, err3_q;
  lpa_pkg::cmp_e   cmp3_q;

  always_comb begin
    corr_ext = in_range2_q ? AddW'(corr_rd) : '0;
    lse_sum  = AddW'($signed(hi2_q)) + corr_ext;
    // correction is never negative, so only the top can be crossed
    lse_ovf  = $signed(lse_sum) > $signed(AddW'($signed(MaxVal)));
    if (add2_q) begin
      rv3_d  = lse_ovf ? MaxVal : lse_sum[VW-1:0];
      err3_d = lse_ovf;
    end else begin
      rv3_d  = rv2_q;
      err3_d = err2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      rv3_q  <= rv3_d;
      rz3_q  <= rz2_q;
      err3_q <= err3_d;
      cmp3_q <= cmp2_q;
    end
  end

  assign m_axis_tdata_o = OutW'({cmp3_q, err3_q, rz3_q, rv3_q});

  // ---------------- assertions ----------------
  a_zero_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && rz3_q |-> rv3_q == '0)
    else $error("zero-probability result with non-zero value");

  a_zero_no_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && rz3_q |-> !err3_q)
    else $error("range error on a zero-probability result");

  a_cmp_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && cmp3_q != lpa_pkg::CMP_EQ |-> !err3_q && !rz3_q && rv3_q == '0)
    else $error("compare result carries value or flags");

  a_mid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !adv2 |=> v2_q && $stable(rv2_q) && $stable(hi2_q))
    else $error("stage 2 word lost under stall");

endmodule
